// ===== hw/rtl/juhc_pkg.sv =====
// Package for the Johab / Unicode Hangul syllable codec.
// Holds syllable constants and the jamo mapping functions; no dependencies.
`default_nettype none

package juhc_pkg;

    localparam int CodeW = 21;
    localparam int OffW  = 14;   // syllable offset, 0..11171
    localparam int QW    = 9;    // offset / 28, 0..398
    localparam int JamoW = 5;

    localparam logic [15:0] SylBase  = 16'hAC00;
    localparam logic [15:0] SylLast  = 16'hD7A3;
    localparam logic [15:0] JohabTop = 16'h8000;

    // Reciprocals for the two constant divisions (floor exact over the used range)
    localparam logic [12:0] Recip7   = 13'd4682;   // x / 7  = (x * Recip7)  >> 15, x < 4096
    localparam int          Recip7Sh = 15;
    localparam logic [8:0]  Recip21  = 9'd391;     // q / 21 = (q * Recip21) >> 13, q < 431
    localparam int          Recip21Sh = 13;

    localparam logic OpDecode = 1'b0;   // Johab to Unicode
    localparam logic OpEncode = 1'b1;   // Unicode to Johab

    // Jamo code to 1-based linear index, zero marks an illegal code
    function automatic logic [JamoW-1:0] ini_lin(input logic [JamoW-1:0] c);
        logic [JamoW-1:0] r;
        r = '0;
        if (c >= 5'd2 && c <= 5'd20) r = c - 5'd1;
        return r;
    endfunction

    function automatic logic [JamoW-1:0] med_lin(input logic [JamoW-1:0] c);
        logic [JamoW-1:0] r;
        r = '0;
        if (c >= 5'd3 && c <= 5'd7)        r = c - 5'd2;
        else if (c >= 5'd10 && c <= 5'd15) r = c - 5'd4;
        else if (c >= 5'd18 && c <= 5'd23) r = c - 5'd6;
        else if (c >= 5'd26 && c <= 5'd29) r = c - 5'd8;
        return r;
    endfunction

    function automatic logic [JamoW-1:0] fin_lin(input logic [JamoW-1:0] c);
        logic [JamoW-1:0] r;
        r = '0;
        if (c >= 5'd1 && c <= 5'd17)       r = c;
        else if (c >= 5'd19 && c <= 5'd29) r = c - 5'd1;
        return r;
    endfunction

    // 0-based linear index to jamo code
    function automatic logic [JamoW-1:0] lin_ini(input logic [JamoW-1:0] x);
        return x + 5'd2;
    endfunction

    function automatic logic [JamoW-1:0] lin_med(input logic [JamoW-1:0] x);
        logic [JamoW-1:0] r;
        if (x <= 5'd4)       r = x + 5'd3;
        else if (x <= 5'd10) r = x + 5'd5;
        else if (x <= 5'd16) r = x + 5'd7;
        else                 r = x + 5'd9;
        return r;
    endfunction

    function automatic logic [JamoW-1:0] lin_fin(input logic [JamoW-1:0] x);
        logic [JamoW-1:0] r;
        if (x <= 5'd16) r = x + 5'd1;
        else            r = x + 5'd2;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/johab_unicode_hangul_codec.sv =====
// Top level of the Johab / Unicode Hangul syllable codec: a four-stage pipeline.
// Depends on juhc_pkg for constants and jamo mapping functions.
// An accepted input transaction passes through stages 1 to 4 in order to its result on m_.
// Throughput: one transaction per cycle while m_tready holds; each stage holds one item and refills
// as soon as its content moves on, so bubbles collapse under output stalls.
// Reset: aresetn (synchronous, active low) clears all stage valid bits.
`default_nettype none

module johab_unicode_hangul_codec (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [20:0] code_in, [23:21] zero
    input  wire logic        s_tuser,   // [0] op
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] code_out
    output logic             m_tuser    // [0] valid_res
);

    // ------------------------------------------------------------------
    // Stage handshake: a stage loads when it is empty or its content
    // leaves in the same cycle.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign m_tvalid = v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: jamo table lookups (decode) and syllable range check (encode)
    // ------------------------------------------------------------------
    logic [juhc_pkg::CodeW-1:0] code_in;
    logic [juhc_pkg::JamoW-1:0] ini_l, med_l, fin_l;
    logic [15:0]                cp_diff;
    logic                       in_range;

    logic                        op1_reg,  ok1_reg;
    logic [juhc_pkg::JamoW-1:0]  i1_reg, m1_reg, f1_reg;   // 0-based indices
    logic [juhc_pkg::OffW-1:0]   off1_reg;
    logic                        ok1_next;

    assign code_in  = s_tdata[juhc_pkg::CodeW-1:0];
    assign ini_l    = juhc_pkg::ini_lin(code_in[14:10]);
    assign med_l    = juhc_pkg::med_lin(code_in[9:5]);
    assign fin_l    = juhc_pkg::fin_lin(code_in[4:0]);
    // bits above 15 must be clear for a syllable code point
    assign in_range = (code_in[20:16] == 5'd0)
                   && (code_in[15:0] >= juhc_pkg::SylBase)
                   && (code_in[15:0] <= juhc_pkg::SylLast);
    assign cp_diff  = code_in[15:0] - juhc_pkg::SylBase;

    always_comb begin
        unique case (s_tuser)
            juhc_pkg::OpDecode: ok1_next = (ini_l != '0) && (med_l != '0) && (fin_l != '0);
            juhc_pkg::OpEncode: ok1_next = in_range;
            default:            ok1_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            op1_reg  <= s_tuser;
            ok1_reg  <= ok1_next;
            i1_reg   <= ini_l - 5'd1;
            m1_reg   <= med_l - 5'd1;
            f1_reg   <= fin_l - 5'd1;
            off1_reg <= cp_diff[juhc_pkg::OffW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: decode forms ini*21 + med; encode divides the offset by 28
    // as (off >> 2) / 7 through a reciprocal multiply.
    // ------------------------------------------------------------------
    logic [24:0]               q_prod;
    logic [juhc_pkg::QW-1:0]   t2_next;

    logic                        op2_reg, ok2_reg;
    logic [juhc_pkg::QW-1:0]     t2_reg;
    logic [juhc_pkg::JamoW-1:0]  f2_reg;
    logic [juhc_pkg::QW-1:0]     q2_reg;
    logic [juhc_pkg::OffW-1:0]   off2_reg;

    assign q_prod  = {1'b0, off1_reg[juhc_pkg::OffW-1:2]} * {12'd0, juhc_pkg::Recip7};
    assign t2_next = {4'd0, i1_reg} * 9'd21 + {4'd0, m1_reg};

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            op2_reg  <= op1_reg;
            ok2_reg  <= ok1_reg;
            t2_reg   <= t2_next;
            f2_reg   <= f1_reg;
            q2_reg   <= q_prod[juhc_pkg::Recip7Sh +: juhc_pkg::QW];
            off2_reg <= off1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: decode finishes the code point; encode takes the final
    // remainder and divides the quotient by 21.
    // ------------------------------------------------------------------
    logic [15:0]               uni_next;
    logic [juhc_pkg::OffW-1:0] fin_rem;
    logic [17:0]               iq_prod;

    logic                        op3_reg, ok3_reg;
    logic [15:0]                 uni3_reg;
    logic [juhc_pkg::JamoW-1:0]  iq3_reg, fin3_reg;
    logic [juhc_pkg::QW-1:0]     q3_reg;

    assign uni_next = {7'd0, t2_reg} * 16'd28 + {11'd0, f2_reg} + juhc_pkg::SylBase;
    assign fin_rem  = off2_reg - {5'd0, q2_reg} * 14'd28;
    assign iq_prod  = {9'd0, q2_reg} * {9'd0, juhc_pkg::Recip21};

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            op3_reg  <= op2_reg;
            ok3_reg  <= ok2_reg;
            uni3_reg <= uni_next;
            iq3_reg  <= iq_prod[juhc_pkg::Recip21Sh +: juhc_pkg::JamoW];
            fin3_reg <= fin_rem[juhc_pkg::JamoW-1:0];
            q3_reg   <= q2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: encode takes the medial remainder and packs the Johab word;
    // select by op and force zero on an illegal or out-of-range code.
    // ------------------------------------------------------------------
    logic [juhc_pkg::QW-1:0] med_rem;
    logic [15:0]             johab_word;
    logic [15:0]             res_next;

    logic        valid4_reg;
    logic [15:0] code4_reg;

    assign med_rem    = q3_reg - {4'd0, iq3_reg} * 9'd21;
    assign johab_word = juhc_pkg::JohabTop
                      | {1'b0, juhc_pkg::lin_ini(iq3_reg), 10'd0}
                      | {6'd0, juhc_pkg::lin_med(med_rem[juhc_pkg::JamoW-1:0]), 5'd0}
                      | {11'd0, juhc_pkg::lin_fin(fin3_reg)};

    always_comb begin
        unique case (op3_reg)
            juhc_pkg::OpDecode: res_next = uni3_reg;
            juhc_pkg::OpEncode: res_next = johab_word;
            default:            res_next = 16'd0;
        endcase
        if (!ok3_reg) res_next = 16'd0;
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            valid4_reg <= ok3_reg;
            code4_reg  <= res_next;
        end
    end

    assign m_tdata = code4_reg;
    assign m_tuser = valid4_reg;

endmodule

`default_nettype wire
